[src/chte_pkg.sv]
// ----------------------------------------------------------------------------
// chte_pkg
// Shared codes, command and status types of the cuckoo hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

	// function codes on the input tuser
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_LOOKUP = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;
	// unassigned code, handled as a lookup
	localparam logic [1:0] FN_SPARE  = 2'd3;

	// result status codes
	localparam logic [2:0] RS_NEW     = 3'd0;
	localparam logic [2:0] RS_UPDATED = 3'd1;
	localparam logic [2:0] RS_FAILED  = 3'd2;
	localparam logic [2:0] RS_HIT     = 3'd3;
	localparam logic [2:0] RS_MISS    = 3'd4;
	localparam logic [2:0] RS_CLEARED = 3'd5;

	// register indexes (paddr[4:3])
	localparam logic [1:0] REG_SEED_ONE   = 2'd0;
	localparam logic [1:0] REG_SEED_TWO   = 2'd1;
	localparam logic [1:0] REG_TABLE_SIZE = 2'd2;
	localparam logic [1:0] REG_MAX_KICKS  = 2'd3;

	localparam logic [63:0] SEED_ONE_RST   = 64'd14695981039346656037;
	localparam logic [63:0] SEED_TWO_RST   = 64'd1;
	localparam logic [10:0] TABLE_SIZE_RST = 11'd1024;
	localparam logic [6:0]  MAX_KICKS_RST  = 7'd32;
	localparam logic [6:0]  KICKS_CEIL     = 7'd64;

	// fnv prime 0x100000001b3 = 0x1b3 + 2^40
	localparam logic [63:0] FNV_MULT_LO    = 64'h1B3;
	localparam int          FNV_MULT_SHIFT = 40;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_HASH_STEP,
		OP_MOD_STEP,
		OP_POS,
		OP_RD_P1,
		OP_RD_P2,
		OP_DECIDE,
		OP_KSWAP,
		OP_RD_NXT,
		OP_KCHK,
		OP_SWEEP,
		OP_CLEARED,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_item;
		logic hash_last;
		logic mod_last;
		logic sweep_last;
		logic need_kick;
		logic kick_more;
	} dp_stat_t;

endpackage

[src/chte_ram.sv]
// ----------------------------------------------------------------------------
// chte_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/chte_ctrl.sv]
// ----------------------------------------------------------------------------
// chte_ctrl
// Sequencer of the engine: issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module chte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output chte_pkg::dp_cmd_t  cmd,
	input  chte_pkg::dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_DISPATCH,
		S_HASH,
		S_MOD,
		S_POS,
		S_RD1,
		S_RD2,
		S_DECIDE,
		S_KSWAP,
		S_KREAD,
		S_KCHK,
		S_CLRFIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   clear_q;
	logic   kick_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		unique case (state_q)
			S_SWEEP:    cmd.op = chte_pkg::OP_SWEEP;
			S_IDLE:     cmd.op = s_tvalid ? chte_pkg::OP_LOAD : chte_pkg::OP_NONE;
			S_DISPATCH: cmd.op = chte_pkg::OP_NONE;
			S_HASH:     cmd.op = chte_pkg::OP_HASH_STEP;
			S_MOD:      cmd.op = chte_pkg::OP_MOD_STEP;
			S_POS:      cmd.op = chte_pkg::OP_POS;
			S_RD1:      cmd.op = chte_pkg::OP_RD_P1;
			S_RD2:      cmd.op = chte_pkg::OP_RD_P2;
			S_DECIDE:   cmd.op = chte_pkg::OP_DECIDE;
			S_KSWAP:    cmd.op = chte_pkg::OP_KSWAP;
			S_KREAD:    cmd.op = chte_pkg::OP_RD_NXT;
			S_KCHK:     cmd.op = chte_pkg::OP_KCHK;
			S_CLRFIN:   cmd.op = chte_pkg::OP_CLEARED;
			S_DONE:     cmd.op = out_free ? chte_pkg::OP_OUT_LOAD : chte_pkg::OP_NONE;
			default:    cmd.op = chte_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			clear_q    <= 1'b0;
			kick_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result register is loaded in S_DONE once the output is free, else held until taken
			m_tvalid_q <= (state_q == S_DONE && out_free) || (m_tvalid_q && !m_tready);
			unique case (state_q)
				S_SWEEP: begin
					if (stat.sweep_last) begin
						state_q <= clear_q ? S_CLRFIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						kick_q  <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (stat.clear_item) begin
						clear_q <= 1'b1;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (stat.hash_last) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (stat.mod_last) begin
						state_q <= S_POS;
					end
				end
				S_POS:    state_q <= kick_q ? S_KREAD : S_RD1;
				S_RD1:    state_q <= S_RD2;
				S_RD2:    state_q <= S_DECIDE;
				S_DECIDE: begin
					if (stat.need_kick) begin
						kick_q  <= 1'b1;
						state_q <= S_KSWAP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_KSWAP:  state_q <= S_HASH;
				S_KREAD:  state_q <= S_KCHK;
				S_KCHK:   state_q <= stat.kick_more ? S_KSWAP : S_DONE;
				S_CLRFIN: begin
					clear_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken but sequencer stayed idle");

	a_done_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> m_tvalid)
		else $error("finished request did not reach the output register");

	a_probe_not_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD1) |-> !kick_q)
		else $error("first probe issued during an eviction chain");

endmodule

[src/chte_dp.sv]
// ----------------------------------------------------------------------------
// chte_dp
// Datapath: item registers, byte-serial hashes, radix-16 remainder, slot
// store, eviction bookkeeping and the result registers.
// ----------------------------------------------------------------------------
module chte_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  chte_pkg::dp_cmd_t  cmd,
	output chte_pkg::dp_stat_t stat,
	input  logic [63:0]        seed_one,
	input  logic [63:0]        seed_two,
	input  logic [10:0]        table_size,
	input  logic [6:0]         max_kicks,
	input  logic [1:0]         in_func,
	input  logic [63:0]        in_key,
	input  logic [3:0]         in_len,
	input  logic [31:0]        in_value,
	input  logic [31:0]        in_scope,
	output logic [2:0]         out_status,
	output logic [31:0]        out_value,
	output logic [63:0]        out_lkey,
	output logic [3:0]         out_llen,
	output logic [31:0]        out_lval,
	output logic [31:0]        out_lscope,
	output logic [6:0]         out_kicks,
	output logic [10:0]        out_count
);

	localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW      = $clog2(TABLE_DEPTH + 1);
	localparam int KW      = 8 * KEY_BYTES;
	localparam int IW      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int VB      = VALUE_BITS;
	localparam int VAL_LSB = 32;
	localparam int LEN_LSB = 32 + VB;
	localparam int KEY_LSB = 36 + VB;
	localparam int VLD_BIT = 36 + VB + KW;
	localparam int WW      = VLD_BIT + 1;

	// item in hand (new entry, later the evicted one)
	logic [1:0]    func_q;
	logic [KW-1:0] cand_key_q;
	logic [3:0]    cand_len_q;
	logic [VB-1:0] cand_val_q;
	logic [31:0]   cand_scope_q;

	logic [63:0]   h1_q, h2_q;
	logic [IW-1:0] idx_q;
	logic [3:0]    mcnt_q;
	logic [SW-1:0] r1_q, r2_q;
	logic [AW-1:0] p1_q, p2_q, cur_q, nxt_q, sweep_q;
	logic [6:0]    k_q;
	logic [SW-1:0] count_q;
	logic [WW-1:0] e1_q, slot_q;

	logic [2:0]    res_status_q;
	logic [31:0]   res_value_q;
	logic [63:0]   res_lkey_q;
	logic [3:0]    res_llen_q;
	logic [31:0]   res_lval_q, res_lscope_q;
	logic [6:0]    res_kicks_q;

	logic [SW-1:0] size_w;
	logic [6:0]    limit_w;
	logic [3:0]    len_w;
	logic [KW-1:0] mask_w;
	logic [63:0]   h1_n, h2_n, x1, x2;
	logic [7:0]    byte_w;
	logic [SW-1:0] r1_n, r2_n;
	logic [AW-1:0] q_w;
	logic [SW-1:0] p_inc;
	logic [AW-1:0] nxt_w;

	logic          we;
	logic [AW-1:0] waddr;
	logic [WW-1:0] wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [WW-1:0] rdata;

	logic          v1, v2, hold1, hold2, is_insert;

	chte_ram #(.WIDTH(WW), .DEPTH(TABLE_DEPTH)) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// clamp of the size and kick registers
	always_comb begin
		if (table_size < 11'd4) begin
			size_w = SW'(4);
		end else if (32'(table_size) > TABLE_DEPTH) begin
			size_w = SW'(TABLE_DEPTH);
		end else begin
			size_w = SW'(table_size);
		end
		if (max_kicks == 7'd0) begin
			limit_w = 7'd1;
		end else if (max_kicks > chte_pkg::KICKS_CEIL) begin
			limit_w = chte_pkg::KICKS_CEIL;
		end else begin
			limit_w = max_kicks;
		end
	end

	always_comb begin
		len_w = (in_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_len;
		for (int i = 0; i < KEY_BYTES; i++) begin
			mask_w[8*i +: 8] = (4'(i) < len_w) ? 8'hFF : 8'h00;
		end
	end

	// one fnv-1a byte for both seeds; bytes past the key length leave h alone
	always_comb begin
		byte_w = cand_key_q[8*idx_q +: 8];
		x1     = h1_q ^ {56'd0, byte_w};
		x2     = h2_q ^ {56'd0, byte_w};
		if (4'(idx_q) < cand_len_q) begin
			h1_n = x1 * chte_pkg::FNV_MULT_LO + (x1 << chte_pkg::FNV_MULT_SHIFT);
			h2_n = x2 * chte_pkg::FNV_MULT_LO + (x2 << chte_pkg::FNV_MULT_SHIFT);
		end else begin
			h1_n = h1_q;
			h2_n = h2_q;
		end
	end

	// four remainder bits per cycle, msb first
	always_comb begin
		logic [5:0]    bp;
		logic [SW:0]   t1, t2;
		r1_n = r1_q;
		r2_n = r2_q;
		for (int j = 0; j < 4; j++) begin
			bp = {~mcnt_q, 2'(3 - j)};
			t1 = {r1_n, h1_q[bp]};
			t2 = {r2_n, h2_q[bp]};
			if (t1 >= {1'b0, size_w}) begin
				t1 = t1 - {1'b0, size_w};
			end
			if (t2 >= {1'b0, size_w}) begin
				t2 = t2 - {1'b0, size_w};
			end
			r1_n = t1[SW-1:0];
			r2_n = t2[SW-1:0];
		end
	end

	always_comb begin
		p_inc = r1_q + SW'(1);
		if (r2_q == r1_q) begin
			q_w = (p_inc == size_w) ? '0 : p_inc[AW-1:0];
		end else begin
			q_w = r2_q[AW-1:0];
		end
	end

	assign nxt_w = (cur_q == p1_q) ? p2_q : p1_q;

	assign is_insert = (func_q == chte_pkg::FN_INSERT);
	assign v1        = e1_q[VLD_BIT];
	assign v2        = rdata[VLD_BIT];
	assign hold1     = v1 && e1_q[KEY_LSB +: KW] == cand_key_q
		&& e1_q[LEN_LSB +: 4] == cand_len_q;
	assign hold2     = v2 && rdata[KEY_LSB +: KW] == cand_key_q
		&& rdata[LEN_LSB +: 4] == cand_len_q;

	assign stat.clear_item = (func_q == chte_pkg::FN_CLEAR);
	assign stat.hash_last  = (idx_q == IW'(KEY_BYTES - 1));
	assign stat.mod_last   = (mcnt_q == 4'd15);
	assign stat.sweep_last = (sweep_q == AW'(TABLE_DEPTH - 1));
	assign stat.need_kick  = is_insert && v1 && v2 && !hold1 && !hold2;
	assign stat.kick_more  = rdata[VLD_BIT] && (k_q < limit_w);

	// store port selection
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = {1'b1, cand_key_q, cand_len_q, cand_val_q, cand_scope_q};
		re    = 1'b0;
		raddr = p1_q;
		case (cmd.op)
			chte_pkg::OP_SWEEP: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
			end
			chte_pkg::OP_RD_P1: re = 1'b1;
			chte_pkg::OP_RD_P2: begin
				re    = 1'b1;
				raddr = p2_q;
			end
			chte_pkg::OP_RD_NXT: begin
				re    = 1'b1;
				raddr = nxt_w;
			end
			chte_pkg::OP_DECIDE: begin
				// matching key wins over an empty slot, first slot before second
				if (is_insert) begin
					if (hold1) begin
						we    = 1'b1;
						waddr = p1_q;
					end else if (hold2) begin
						we    = 1'b1;
						waddr = p2_q;
					end else if (!v1) begin
						we    = 1'b1;
						waddr = p1_q;
					end else if (!v2) begin
						we    = 1'b1;
						waddr = p2_q;
					end
				end
			end
			chte_pkg::OP_KSWAP: we = 1'b1;
			chte_pkg::OP_KCHK: begin
				if (!rdata[VLD_BIT]) begin
					we    = 1'b1;
					waddr = nxt_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sweep_q <= '0;
			idx_q   <= '0;
			mcnt_q  <= '0;
			k_q     <= '0;
			func_q  <= chte_pkg::FN_LOOKUP;
		end else begin
			case (cmd.op)
				chte_pkg::OP_LOAD: begin
					func_q       <= in_func;
					cand_key_q   <= in_key[KW-1:0] & mask_w;
					cand_len_q   <= len_w;
					cand_val_q   <= VB'(in_value);
					cand_scope_q <= in_scope;
					k_q          <= '0;
					h1_q         <= seed_one;
					h2_q         <= seed_two;
					idx_q        <= '0;
					mcnt_q       <= '0;
					r1_q         <= '0;
					r2_q         <= '0;
					res_status_q <= chte_pkg::RS_MISS;
					res_value_q  <= '0;
					res_lkey_q   <= '0;
					res_llen_q   <= '0;
					res_lval_q   <= '0;
					res_lscope_q <= '0;
					res_kicks_q  <= '0;
				end
				chte_pkg::OP_HASH_STEP: begin
					h1_q  <= h1_n;
					h2_q  <= h2_n;
					idx_q <= idx_q + IW'(1);
				end
				chte_pkg::OP_MOD_STEP: begin
					r1_q   <= r1_n;
					r2_q   <= r2_n;
					mcnt_q <= mcnt_q + 4'd1;
				end
				chte_pkg::OP_POS: begin
					p1_q <= r1_q[AW-1:0];
					p2_q <= q_w;
				end
				chte_pkg::OP_RD_P2: e1_q <= rdata;
				chte_pkg::OP_DECIDE: begin
					if (is_insert) begin
						if (hold1 || hold2) begin
							res_status_q <= chte_pkg::RS_UPDATED;
						end else if (!v1 || !v2) begin
							res_status_q <= chte_pkg::RS_NEW;
							count_q      <= count_q + SW'(1);
						end else begin
							cur_q  <= p1_q;
							slot_q <= e1_q;
						end
					end else if (hold1) begin
						res_status_q <= chte_pkg::RS_HIT;
						res_value_q  <= 32'(e1_q[VAL_LSB +: VB]);
					end else if (hold2) begin
						res_status_q <= chte_pkg::RS_HIT;
						res_value_q  <= 32'(rdata[VAL_LSB +: VB]);
					end
				end
				chte_pkg::OP_KSWAP: begin
					// carried item goes in, resident comes out
					cand_key_q   <= slot_q[KEY_LSB +: KW];
					cand_len_q   <= slot_q[LEN_LSB +: 4];
					cand_val_q   <= slot_q[VAL_LSB +: VB];
					cand_scope_q <= slot_q[31:0];
					k_q          <= k_q + 7'd1;
					h1_q         <= seed_one;
					h2_q         <= seed_two;
					idx_q        <= '0;
					mcnt_q       <= '0;
					r1_q         <= '0;
					r2_q         <= '0;
				end
				chte_pkg::OP_RD_NXT: nxt_q <= nxt_w;
				chte_pkg::OP_KCHK: begin
					res_kicks_q <= k_q;
					if (!rdata[VLD_BIT]) begin
						res_status_q <= chte_pkg::RS_NEW;
						count_q      <= count_q + SW'(1);
					end else begin
						slot_q <= rdata;
						cur_q  <= nxt_q;
						if (k_q >= limit_w) begin
							res_status_q <= chte_pkg::RS_FAILED;
							res_lkey_q   <= 64'(cand_key_q);
							res_llen_q   <= cand_len_q;
							res_lval_q   <= 32'(cand_val_q);
							res_lscope_q <= cand_scope_q;
						end
					end
				end
				chte_pkg::OP_SWEEP: begin
					sweep_q <= stat.sweep_last ? '0 : sweep_q + AW'(1);
				end
				chte_pkg::OP_CLEARED: begin
					count_q      <= '0;
					res_status_q <= chte_pkg::RS_CLEARED;
				end
				chte_pkg::OP_OUT_LOAD: begin
					out_status <= res_status_q;
					out_value  <= res_value_q;
					out_lkey   <= res_lkey_q;
					out_llen   <= res_llen_q;
					out_lval   <= res_lval_q;
					out_lscope <= res_lscope_q;
					out_kicks  <= res_kicks_q;
					out_count  <= 11'(count_q);
				end
				default: ;
			endcase
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SW'(TABLE_DEPTH))
		else $error("occupied count above table depth");

	a_kicks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= chte_pkg::KICKS_CEIL)
		else $error("eviction chain ran past the kick ceiling");

	a_swap_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == chte_pkg::OP_KSWAP) |=> (k_q != 7'd0))
		else $error("swap not counted");

endmodule

[src/cuckoo_hash_table_engine_core.sv]
// ----------------------------------------------------------------------------
// cuckoo_hash_table_engine_core
// Two-choice cuckoo hash table with fnv-1a slot positions and eviction chains.
//
//   port group   dir  content
//   s_*          in   request: tuser func, tdata key/length/value/scope
//   m_*          out  result: tuser status, tdata value/leftover/kicks/count
//   p*           in   register port, 64-bit data, registers at 8*index
//
// Lookup or insert runs through the byte-serial hash over KEY_BYTES bytes and the
// 4-bit-per-cycle remainder; each eviction rehashes the evicted item the same way.
// Clear sweeps every slot of the table before its result is given.
// After reset a clearing pass over all TABLE_DEPTH slots runs; s_tready stays low.
// One request in flight; the next is taken while a result waits on m_tready.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_engine_core #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key_bytes[63:0], key_length[67:64], value_in[99:68], scope_in[131:100]
	input  logic [135:0] s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value_out[31:0], leftover_key[95:32], leftover_length[99:96],
	// leftover_value[131:100], leftover_scope[163:132], kicks_used[170:164],
	// entry_count[181:171]
	output logic [183:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [63:0] seed_one_q, seed_two_q;
	logic [10:0] table_size_q;
	logic [6:0]  max_kicks_q;

	chte_pkg::dp_cmd_t  cmd;
	chte_pkg::dp_stat_t stat;

	logic [2:0]  out_status;
	logic [31:0] out_value, out_lval, out_lscope;
	logic [63:0] out_lkey;
	logic [3:0]  out_llen;
	logic [6:0]  out_kicks;
	logic [10:0] out_count;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q   <= chte_pkg::SEED_ONE_RST;
			seed_two_q   <= chte_pkg::SEED_TWO_RST;
			table_size_q <= chte_pkg::TABLE_SIZE_RST;
			max_kicks_q  <= chte_pkg::MAX_KICKS_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:3])
				chte_pkg::REG_SEED_ONE:   seed_one_q   <= pwdata;
				chte_pkg::REG_SEED_TWO:   seed_two_q   <= pwdata;
				chte_pkg::REG_TABLE_SIZE: table_size_q <= pwdata[10:0];
				chte_pkg::REG_MAX_KICKS:  max_kicks_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			chte_pkg::REG_SEED_ONE:   prdata = seed_one_q;
			chte_pkg::REG_SEED_TWO:   prdata = seed_two_q;
			chte_pkg::REG_TABLE_SIZE: prdata = 64'(table_size_q);
			chte_pkg::REG_MAX_KICKS:  prdata = 64'(max_kicks_q);
			default:                  prdata = '0;
		endcase
	end

	chte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	chte_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BYTES   (KEY_BYTES),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.seed_one   (seed_one_q),
		.seed_two   (seed_two_q),
		.table_size (table_size_q),
		.max_kicks  (max_kicks_q),
		.in_func    (s_tuser),
		.in_key     (s_tdata[63:0]),
		.in_len     (s_tdata[67:64]),
		.in_value   (s_tdata[99:68]),
		.in_scope   (s_tdata[131:100]),
		.out_status (out_status),
		.out_value  (out_value),
		.out_lkey   (out_lkey),
		.out_llen   (out_llen),
		.out_lval   (out_lval),
		.out_lscope (out_lscope),
		.out_kicks  (out_kicks),
		.out_count  (out_count)
	);

	assign m_tuser = out_status;
	assign m_tdata = {2'b00, out_count, out_kicks, out_lscope, out_lval, out_llen,
		out_lkey, out_value};

endmodule
